>>> src/plbt_pkg.sv
// Shared types, constants and helpers for the prose block line terminator scanner.
// No dependencies; every other file in src imports this package.
package plbt_pkg;

    localparam int LINE_LIMIT_DEF = 512;
    localparam int CHAR_W         = 21;
    localparam int FENCE_W        = 8;
    localparam int KWI_W          = 3;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    // register index of keyword_select (paddr[2] selects the word)
    localparam logic REG_KEYWORD = 1'b0;

    localparam logic [CHAR_W-1:0] CH_TAB       = CHAR_W'(9);
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = CHAR_W'(10);
    localparam logic [CHAR_W-1:0] CH_CR        = CHAR_W'(13);
    localparam logic [CHAR_W-1:0] CH_SPACE     = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] CH_BACKTICK  = CHAR_W'(96);
    localparam logic [CHAR_W-1:0] CH_TILDE     = CHAR_W'(126);
    localparam logic [CHAR_W-1:0] CH_OPEN_BR   = CHAR_W'(123);
    localparam logic [CHAR_W-1:0] CH_CLOSE_BR  = CHAR_W'(125);
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = CHAR_W'(95);
    localparam int                FENCE_MIN    = 3;

    localparam logic [KWI_W-1:0] KLEN_EXAMPLE = KWI_W'(7);
    localparam logic [KWI_W-1:0] KLEN_TEST    = KWI_W'(4);

    typedef enum logic {
        REQ_CHAR = 1'b0,
        REQ_END  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        KIND_TEXT   = 2'd0,
        KIND_CLOSE  = 2'd1,
        KIND_HEADER = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CL_LEAD  = 3'b001,
        CL_BRACE = 3'b010,
        CL_OTHER = 3'b100
    } close_t;

    typedef enum logic [6:0] {
        HDR_LEAD  = 7'b0000001,
        HDR_KW    = 7'b0000010,
        HDR_GAP   = 7'b0000100,
        HDR_IDENT = 7'b0001000,
        HDR_TAIL  = 7'b0010000,
        HDR_OK    = 7'b0100000,
        HDR_FAIL  = 7'b1000000
    } hdr_t;

    typedef enum logic [3:0] {
        RUN_LEAD  = 4'b0001,
        RUN_IN    = 4'b0010,
        RUN_TAIL  = 4'b0100,
        RUN_OTHER = 4'b1000
    } run_t;

    // keyword letters: sel 0 "example", sel 1 "test"
    function automatic logic [CHAR_W-1:0] kw_char(input logic sel, input logic [KWI_W-1:0] idx);
        logic [7:0] ch;
        ch = 8'd0;
        if (!sel) begin
            unique case (idx)
                3'd0: ch = 8'h65;
                3'd1: ch = 8'h78;
                3'd2: ch = 8'h61;
                3'd3: ch = 8'h6d;
                3'd4: ch = 8'h70;
                3'd5: ch = 8'h6c;
                3'd6: ch = 8'h65;
                default: ch = 8'd0;
            endcase
        end else begin
            unique case (idx)
                3'd0: ch = 8'h74;
                3'd1: ch = 8'h65;
                3'd2: ch = 8'h73;
                3'd3: ch = 8'h74;
                default: ch = 8'd0;
            endcase
        end
        return CHAR_W'(ch);
    endfunction

    function automatic logic blank_code(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic ident_first(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_W'(97) && c <= CHAR_W'(122))
            || (c >= CHAR_W'(65) && c <= CHAR_W'(90))
            || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic ident_rest(input logic [CHAR_W-1:0] c);
        return ident_first(c) || (c >= CHAR_W'(48) && c <= CHAR_W'(57));
    endfunction

endpackage

>>> src/plbt_in_if.sv
// Character channel of the line terminator scanner: valid/ready plus one character word.
// Depends on plbt_pkg for field widths.
interface plbt_in_if
    import plbt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output req_type, output char_code, input ready);
    modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

>>> src/plbt_out_if.sv
// Line result channel of the line terminator scanner: valid/ready plus one result word.
// Depends on plbt_pkg.
interface plbt_out_if
    import plbt_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] line_kind;
    logic       fence_open;
    logic       token_valid;
    logic       region_end;

    modport source (output valid, output line_kind, output fence_open, output token_valid,
                    output region_end, input ready);
    modport sink   (input valid, input line_kind, input fence_open, input token_valid,
                    input region_end, output ready);
endinterface

>>> src/prose_block_line_terminator_scanner.sv
// Top level of the prose block line terminator scanner.
// Depends on plbt_pkg, plbt_in_if and plbt_out_if.
//
// Takes one character word per cycle on chars and returns one line word on lines for each
// newline and for each end-of-input word. A line word ends the region when the line is a lone
// close brace, a keyword header ("example" or "test" by keyword_select, then blanks, an
// identifier and an open brace), or when input ends; inside an open backtick or tilde fence
// only a matching closing fence is recognized. Characters past LINE_LIMIT on a line are
// ignored. A newline or end word passes through the input register and then the result register
// before its line word is presented on lines, and a new character is taken every cycle while
// lines keeps up; chars.ready drops only when the result register is full and stalled.
// keyword_select is at byte address 0 of the APB port and resets to 0.
module prose_block_line_terminator_scanner
    import plbt_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    plbt_in_if.sink           chars,
    plbt_out_if.source        lines,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CW = $clog2(LINE_LIMIT + 1);
    // run length must hold both a full line and a fence length
    localparam int RW = (CW > FENCE_W) ? CW : FENCE_W;

    // configuration
    logic keyword_select_reg;

    // input register
    logic              stg_valid_reg;
    logic              stg_req_reg;
    logic [CHAR_W-1:0] stg_char_reg;

    // line state
    logic [CW-1:0]      line_count_reg, line_count_next;
    logic               line_open_reg, line_open_next;
    close_t             close_reg, close_next;
    hdr_t               hdr_reg, hdr_next;
    logic [KWI_W-1:0]   kwi_reg, kwi_next;
    run_t               run_reg, run_next;
    logic               run_tilde_reg, run_tilde_next;
    logic [RW-1:0]      run_len_reg, run_len_next;
    logic               fence_tilde_reg, fence_tilde_next;
    logic [FENCE_W-1:0] fence_size_reg, fence_size_next;
    logic               seen_text_reg, seen_text_next;

    // result register
    logic       out_valid_reg;
    kind_t      kind_reg, kind_next;
    logic       fence_open_reg;
    logic       token_valid_reg, token_valid_next;
    logic       region_end_reg, region_end_next;

    logic              c_blank, c_cr, is_nl, produce, do_classify, do_feed;
    logic              out_free, stage_fire;
    logic [CHAR_W-1:0] c;
    logic [KWI_W-1:0]  klen;
    logic [CHAR_W-1:0] fence_ch;
    logic              is_fence, closing;
    kind_t             cls_kind;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KEYWORD) ? APB_DW'(keyword_select_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keyword_select_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_KEYWORD)
        begin
            keyword_select_reg <= pwdata[0];
        end
    end

    // handshake: the stage moves on when it makes no result or the result register frees up
    assign out_free    = !out_valid_reg || lines.ready;
    assign c           = stg_char_reg;
    assign is_nl       = (stg_req_reg == REQ_CHAR) && (c == CH_NEWLINE);
    assign produce     = (stg_req_reg == REQ_END) || is_nl;
    assign stage_fire  = stg_valid_reg && (!produce || out_free);
    assign chars.ready = !stg_valid_reg || stage_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            stg_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            stg_req_reg  <= chars.req_type;
            stg_char_reg <= chars.char_code;
        end
    end

    assign c_blank     = blank_code(c);
    assign c_cr        = (c == CH_CR);
    assign do_feed     = (stg_req_reg == REQ_CHAR) && !is_nl && (line_count_reg < CW'(LINE_LIMIT));
    assign do_classify = is_nl || ((stg_req_reg == REQ_END) && line_open_reg);
    assign klen        = keyword_select_reg ? KLEN_TEST : KLEN_EXAMPLE;
    assign fence_ch    = run_tilde_reg ? CH_TILDE : CH_BACKTICK;
    assign is_fence    = (run_len_reg >= RW'(FENCE_MIN));
    assign closing     = (run_reg == RUN_IN) || (run_reg == RUN_TAIL);

    always_comb
    begin
        line_count_next  = line_count_reg;
        line_open_next   = line_open_reg;
        close_next       = close_reg;
        hdr_next         = hdr_reg;
        kwi_next         = kwi_reg;
        run_next         = run_reg;
        run_tilde_next   = run_tilde_reg;
        run_len_next     = run_len_reg;
        fence_tilde_next = fence_tilde_reg;
        fence_size_next  = fence_size_reg;
        seen_text_next   = seen_text_reg;
        cls_kind         = KIND_TEXT;
        kind_next        = KIND_NONE;
        token_valid_next = 1'b0;
        region_end_next  = 1'b0;

        if (stg_req_reg == REQ_CHAR && !is_nl)
        begin
            line_open_next = 1'b1;
        end

        if (do_feed)
        begin
            line_count_next = line_count_reg + CW'(1);

            unique case (close_reg)
                CL_LEAD:
                begin
                    if (!c_blank)
                        close_next = (c == CH_CLOSE_BR) ? CL_BRACE : CL_OTHER;
                end
                CL_BRACE:
                begin
                    if (!c_blank && !c_cr)
                        close_next = CL_OTHER;
                end
                default: ;
            endcase

            unique case (hdr_reg)
                HDR_LEAD:
                begin
                    if (!c_blank)
                    begin
                        if (c == kw_char(keyword_select_reg, '0))
                        begin
                            hdr_next = HDR_KW;
                            kwi_next = KWI_W'(1);
                        end
                        else
                        begin
                            hdr_next = HDR_FAIL;
                        end
                    end
                end
                HDR_KW:
                begin
                    if (kwi_reg < klen)
                    begin
                        if (c == kw_char(keyword_select_reg, kwi_reg))
                            kwi_next = kwi_reg + KWI_W'(1);
                        else
                            hdr_next = HDR_FAIL;
                    end
                    else
                    begin
                        hdr_next = c_blank ? HDR_GAP : HDR_FAIL;
                    end
                end
                HDR_GAP:
                begin
                    if (!c_blank)
                        hdr_next = ident_first(c) ? HDR_IDENT : HDR_FAIL;
                end
                HDR_IDENT:
                begin
                    if (c_blank)
                        hdr_next = HDR_TAIL;
                    else if (c == CH_OPEN_BR)
                        hdr_next = HDR_OK;
                    else if (!ident_rest(c))
                        hdr_next = HDR_FAIL;
                end
                HDR_TAIL:
                begin
                    if (!c_blank)
                        hdr_next = (c == CH_OPEN_BR) ? HDR_OK : HDR_FAIL;
                end
                default: ;
            endcase

            unique case (run_reg)
                RUN_LEAD:
                begin
                    if (!c_blank)
                    begin
                        if (c == CH_BACKTICK || c == CH_TILDE)
                        begin
                            run_next       = RUN_IN;
                            run_tilde_next = (c == CH_TILDE);
                            run_len_next   = RW'(1);
                        end
                        else
                        begin
                            run_next = RUN_OTHER;
                        end
                    end
                end
                RUN_IN:
                begin
                    if (c == fence_ch)
                        run_len_next = run_len_reg + RW'(1);
                    else
                        run_next = (c_blank || c_cr) ? RUN_TAIL : RUN_OTHER;
                end
                RUN_TAIL:
                begin
                    if (!c_blank && !c_cr)
                        run_next = RUN_OTHER;
                end
                default: ;
            endcase
        end

        if (do_classify)
        begin
            if (fence_size_reg == '0)
            begin
                if (close_reg == CL_BRACE)
                begin
                    cls_kind = KIND_CLOSE;
                end
                else if (hdr_reg == HDR_OK)
                begin
                    cls_kind = KIND_HEADER;
                end
                else if (is_fence)
                begin
                    fence_tilde_next = run_tilde_reg;
                    fence_size_next  = run_len_reg[FENCE_W-1:0];
                end
            end
            else if (is_fence && closing && run_tilde_reg == fence_tilde_reg
                     && run_len_reg >= RW'(fence_size_reg))
            begin
                fence_size_next = '0;
            end
        end

        // clear the line at every result
        if (produce)
        begin
            line_count_next = '0;
            line_open_next  = 1'b0;
            close_next      = CL_LEAD;
            hdr_next        = HDR_LEAD;
            kwi_next        = '0;
            run_next        = RUN_LEAD;
            run_tilde_next  = 1'b0;
            run_len_next    = '0;

            if (stg_req_reg == REQ_END)
            begin
                kind_next        = do_classify ? cls_kind : KIND_NONE;
                region_end_next  = 1'b1;
                token_valid_next = seen_text_reg || (do_classify && cls_kind == KIND_TEXT);
                seen_text_next   = 1'b0;
            end
            else
            begin
                kind_next = cls_kind;
                if (cls_kind == KIND_TEXT)
                begin
                    seen_text_next = 1'b1;
                end
                else
                begin
                    region_end_next  = 1'b1;
                    token_valid_next = seen_text_reg;
                    seen_text_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg  <= '0;
            line_open_reg   <= 1'b0;
            close_reg       <= CL_LEAD;
            hdr_reg         <= HDR_LEAD;
            kwi_reg         <= '0;
            run_reg         <= RUN_LEAD;
            run_tilde_reg   <= 1'b0;
            run_len_reg     <= '0;
            fence_tilde_reg <= 1'b0;
            fence_size_reg  <= '0;
            seen_text_reg   <= 1'b0;
        end
        else if (stage_fire)
        begin
            line_count_reg  <= line_count_next;
            line_open_reg   <= line_open_next;
            close_reg       <= close_next;
            hdr_reg         <= hdr_next;
            kwi_reg         <= kwi_next;
            run_reg         <= run_next;
            run_tilde_reg   <= run_tilde_next;
            run_len_reg     <= run_len_next;
            fence_tilde_reg <= fence_tilde_next;
            fence_size_reg  <= fence_size_next;
            seen_text_reg   <= seen_text_next;
        end
    end

    // result register: load a word on a producing step, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (lines.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && produce)
        begin
            kind_reg        <= kind_next;
            fence_open_reg  <= (fence_size_next != '0);
            token_valid_reg <= token_valid_next;
            region_end_reg  <= region_end_next;
        end
    end

    assign lines.valid       = out_valid_reg;
    assign lines.line_kind   = kind_reg;
    assign lines.fence_open  = fence_open_reg;
    assign lines.token_valid = token_valid_reg;
    assign lines.region_end  = region_end_reg;

endmodule

>>> tb/plbt_line_checker.sv
// Line scanner checker: watches the character and line channels and the APB port,
// predicts each line word and compares it with the word the scanner returns.
// Depends on plbt_pkg, plbt_in_if and plbt_out_if.
module plbt_line_checker
    import plbt_pkg::*;
#(
    parameter int                LINE_LIMIT = LINE_LIMIT_DEF,
    parameter logic [APB_AW-1:0] KW_ADDR    = '0
) (
    input  logic              clk,
    input  logic              rst_n,
    plbt_in_if                chars,
    plbt_out_if               lines,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                mismatches,
    output int                pending
);

    localparam int COL_W = $clog2(LINE_LIMIT + 1);

    typedef struct packed {
        kind_t kind;
        logic  fence_open;
        logic  token_valid;
        logic  region_end;
    } line_word_t;

    logic             kw_sel;
    logic [COL_W-1:0] col;
    logic             line_pending;
    close_t           brace_st;
    hdr_t             hdr_st;
    logic [KWI_W-1:0] kw_pos;
    run_t             run_st;
    logic             run_tilde;
    logic [COL_W-1:0] run_len;
    logic             fence_tilde;
    logic [FENCE_W-1:0] fence_size;
    logic             region_has_text;
    line_word_t       line_words_q[$];

    function automatic logic blank_char(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic word_start(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_W'("a") && c <= CHAR_W'("z"))
            || (c >= CHAR_W'("A") && c <= CHAR_W'("Z")) || c == CH_UNDERSCORE;
    endfunction

    function automatic logic word_char(input logic [CHAR_W-1:0] c);
        return word_start(c) || (c >= CHAR_W'("0") && c <= CHAR_W'("9"));
    endfunction

    function automatic logic [CHAR_W-1:0] keyword_letter(input logic sel, input int idx);
        string word;
        word = sel ? "test" : "example";
        return (idx < word.len()) ? CHAR_W'(word.getc(idx)) : '0;
    endfunction

    task automatic clear_line();
        col          = '0;
        line_pending = 1'b0;
        brace_st     = CL_LEAD;
        hdr_st       = HDR_LEAD;
        kw_pos       = '0;
        run_st       = RUN_LEAD;
        run_tilde    = 1'b0;
        run_len      = '0;
    endtask

    task automatic scan_char(input logic [CHAR_W-1:0] c);
        logic blank;
        logic cr;
        int   klen;
        blank = blank_char(c);
        cr    = (c == CH_CR);
        klen  = kw_sel ? 4 : 7;

        case (brace_st)
            CL_LEAD:  if (!blank) brace_st = (c == CH_CLOSE_BR) ? CL_BRACE : CL_OTHER;
            CL_BRACE: if (!blank && !cr) brace_st = CL_OTHER;
            default: ;
        endcase

        case (hdr_st)
            HDR_LEAD:
                if (!blank) begin
                    if (c == keyword_letter(kw_sel, 0)) begin
                        hdr_st = HDR_KW;
                        kw_pos = 1;
                    end
                    else
                        hdr_st = HDR_FAIL;
                end
            HDR_KW:
                if (int'(kw_pos) < klen) begin
                    if (c == keyword_letter(kw_sel, int'(kw_pos)))
                        kw_pos = kw_pos + 1'b1;
                    else
                        hdr_st = HDR_FAIL;
                end
                else
                    hdr_st = blank ? HDR_GAP : HDR_FAIL;
            HDR_GAP:
                if (!blank) hdr_st = word_start(c) ? HDR_IDENT : HDR_FAIL;
            HDR_IDENT:
                if (blank)
                    hdr_st = HDR_TAIL;
                else if (c == CH_OPEN_BR)
                    hdr_st = HDR_OK;
                else if (!word_char(c))
                    hdr_st = HDR_FAIL;
            HDR_TAIL:
                if (!blank) hdr_st = (c == CH_OPEN_BR) ? HDR_OK : HDR_FAIL;
            default: ;
        endcase

        case (run_st)
            RUN_LEAD:
                if (!blank) begin
                    if (c == CH_BACKTICK || c == CH_TILDE) begin
                        run_st    = RUN_IN;
                        run_tilde = (c == CH_TILDE);
                        run_len   = 1;
                    end
                    else
                        run_st = RUN_OTHER;
                end
            RUN_IN:
                if (c == (run_tilde ? CH_TILDE : CH_BACKTICK))
                    run_len = run_len + 1'b1;
                else
                    run_st = (blank || cr) ? RUN_TAIL : RUN_OTHER;
            RUN_TAIL:
                if (!blank && !cr) run_st = RUN_OTHER;
            default: ;
        endcase
    endtask

    // classify the pending line and move the fence state
    task automatic end_line(output kind_t kind);
        logic is_fence;
        logic closing;
        is_fence = (run_len >= FENCE_MIN);
        closing  = (run_st == RUN_IN || run_st == RUN_TAIL);
        kind     = KIND_TEXT;
        if (fence_size == '0) begin
            if (brace_st == CL_BRACE)
                kind = KIND_CLOSE;
            else if (hdr_st == HDR_OK)
                kind = KIND_HEADER;
            else if (is_fence) begin
                fence_tilde = run_tilde;
                fence_size  = run_len[FENCE_W-1:0];
            end
        end
        else if (is_fence && run_len >= fence_size && run_tilde == fence_tilde && closing)
            fence_size = '0;
        clear_line();
    endtask

    task automatic take_word(input logic req, input logic [CHAR_W-1:0] c);
        line_word_t w;
        w = '{KIND_TEXT, 1'b0, 1'b0, 1'b0};
        if (req == REQ_CHAR) begin
            if (c != CH_NEWLINE) begin
                line_pending = 1'b1;
                if (col < LINE_LIMIT) begin
                    col = col + 1'b1;
                    scan_char(c);
                end
                return;
            end
            end_line(w.kind);
            if (w.kind == KIND_TEXT)
                region_has_text = 1'b1;
            else begin
                w.region_end    = 1'b1;
                w.token_valid   = region_has_text;
                region_has_text = 1'b0;
            end
        end
        else begin
            w.region_end = 1'b1;
            if (line_pending) begin
                end_line(w.kind);
                if (w.kind == KIND_TEXT) region_has_text = 1'b1;
            end
            else begin
                w.kind = KIND_NONE;
                clear_line();
            end
            w.token_valid   = region_has_text;
            region_has_text = 1'b0;
        end
        w.fence_open = (fence_size != '0);
        line_words_q.push_back(w);
    endtask

    task automatic report(input string field, input int got, input int want);
        $display("%0t: line word %s is %0d, expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        line_word_t w;
        if (!rst_n) begin
            kw_sel          = 1'b0;
            fence_tilde     = 1'b0;
            fence_size      = '0;
            region_has_text = 1'b0;
            clear_line();
            line_words_q.delete();
            mismatches      = 0;
        end
        else begin
            if (chars.valid && chars.ready)
                take_word(chars.req_type, chars.char_code);
            if (psel && penable && pwrite && pready && paddr == KW_ADDR)
                kw_sel = pwdata[0];
            if (lines.valid && lines.ready) begin
                if (line_words_q.size() == 0)
                    report("arrival with none pending, kind", int'(lines.line_kind), -1);
                else begin
                    w = line_words_q.pop_front();
                    if (lines.line_kind !== w.kind)
                        report("line_kind", int'(lines.line_kind), int'(w.kind));
                    if (lines.fence_open !== w.fence_open)
                        report("fence_open", int'(lines.fence_open), int'(w.fence_open));
                    if (lines.token_valid !== w.token_valid)
                        report("token_valid", int'(lines.token_valid), int'(w.token_valid));
                    if (lines.region_end !== w.region_end)
                        report("region_end", int'(lines.region_end), int'(w.region_end));
                end
            end
        end
        pending = line_words_q.size();
    end

endmodule

>>> tb/tb_top.sv
// Top of the line scanner testbench: clock, reset, APB writes, character stimulus and
// result back-pressure, plus the verdict. Depends on plbt_pkg, both channel interfaces,
// the scanner top level and plbt_line_checker.
module tb_top;
    import plbt_pkg::*;

    localparam logic [APB_AW-1:0] KW_ADDR     = APB_AW'({REG_KEYWORD, 2'b00});
    localparam int                STALL_LIMIT = 2000;
    localparam int                SEG_WORDS   = 50;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                pending;

    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                quiet_cycles  = 0;
    int                seg_count     = 0;
    logic              kw_now        = 1'b0;
    logic [CHAR_W-1:0] line_buf[$];

    plbt_in_if  chars ();
    plbt_out_if lines ();

    prose_block_line_terminator_scanner i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .lines   (lines),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    plbt_line_checker #(
        .LINE_LIMIT (LINE_LIMIT_DEF),
        .KW_ADDR    (KW_ADDR)
    ) i_line_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .lines      (lines),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        lines.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((chars.valid && chars.ready) || (lines.valid && lines.ready) || (psel && penable)
                || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[prose_block_line_terminator_scanner] ERROR");
            $finish;
        end
    end

    task automatic write_keyword(input logic v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KW_ADDR;
        pwdata  <= ($urandom() & ~APB_DW'(1)) | APB_DW'(v);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        kw_now  = v;
    endtask

    // hold off until every line word is back, then let the pipeline empty
    task automatic drain();
        chars.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_word(input req_t r, input logic [CHAR_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(negedge clk);
        end
        chars.valid     <= 1'b1;
        chars.req_type  <= r;
        chars.char_code <= c;
        do @(posedge clk); while (!chars.ready);
        @(negedge clk);
        seg_count++;
    endtask

    task automatic send_buf(input logic with_newline);
        foreach (line_buf[i]) send_word(REQ_CHAR, line_buf[i]);
        if (with_newline) send_word(REQ_CHAR, CH_NEWLINE);
        line_buf.delete();
    endtask

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(CHAR_W'(s.getc(i)));
    endfunction

    function automatic void add_blanks(input int n);
        repeat (n) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_letter();
        int k;
        k = $urandom_range(52);
        if (k < 26) return CHAR_W'("a" + k);
        if (k < 52) return CHAR_W'("A" + k - 26);
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_wide();
        // wide code points, some with a low byte that looks like an ASCII marker
        if ($urandom_range(2) == 0)
            return CHAR_W'($urandom_range(1, 4351) * 256 + $urandom_range(32, 126));
        return CHAR_W'($urandom_range(128, 1114111));
    endfunction

    function automatic void add_ident(input logic bad_start);
        line_buf.push_back(bad_start ? CHAR_W'("0" + $urandom_range(9)) : rand_letter());
        repeat ($urandom_range(5))
            line_buf.push_back($urandom_range(3) == 0 ? CHAR_W'("0" + $urandom_range(9))
                                                      : rand_letter());
    endfunction

    function automatic void add_text(input int n);
        int k;
        repeat (n)
        begin
            k = $urandom_range(99);
            if (k < 5)
                line_buf.push_back(rand_wide());
            else if (k < 8)
                line_buf.push_back(CH_CR);
            else if (k < 20)
                line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            else
                line_buf.push_back(CHAR_W'($urandom_range(33, 126)));
        end
    endfunction

    task automatic random_line();
        int                pick;
        int                k;
        int                start;
        string             kw;
        logic [CHAR_W-1:0] fc;
        pick = $urandom_range(99);
        line_buf.delete();
        if (pick < 12)
        begin
            add_blanks($urandom_range(2));
            if ($urandom_range(4) == 0) line_buf.push_back(CH_CR);
            line_buf.push_back(CH_CLOSE_BR);
            add_blanks($urandom_range(2));
            if ($urandom_range(2) == 0) line_buf.push_back(CH_CR);
            if ($urandom_range(4) == 0) line_buf.push_back(CHAR_W'($urandom_range(33, 126)));
        end
        else if (pick < 32)
        begin
            add_blanks($urandom_range(3));
            kw = kw_now ? "test" : "example";
            k = $urandom_range(99);
            start = line_buf.size();
            if (k < 70)
                add_str(kw);
            else if (k < 80)
                add_str(kw_now ? "example" : "test");
            else if (k < 90)
                add_str(kw.substr(0, kw.len() - 2));
            else
            begin
                add_str(kw);
                line_buf[start + $urandom_range(kw.len() - 1)] = rand_letter();
            end
            if ($urandom_range(9) != 0) add_blanks($urandom_range(1, 3));
            add_ident($urandom_range(9) == 0);
            add_blanks($urandom_range(2));
            line_buf.push_back($urandom_range(9) == 0 ? CHAR_W'($urandom_range(33, 126))
                                                      : CH_OPEN_BR);
            if ($urandom_range(1) == 0) add_text($urandom_range(8));
        end
        else if (pick < 48)
        begin
            if ($urandom_range(3) == 0) add_blanks(1);
            fc = $urandom_range(1) ? CH_TILDE : CH_BACKTICK;
            k = ($urandom_range(299) == 0) ? 256 : $urandom_range(1, 6);
            repeat (k) line_buf.push_back(fc);
            case ($urandom_range(2))
                0: ;
                1:
                begin
                    add_blanks($urandom_range(2));
                    if ($urandom_range(1) == 0) line_buf.push_back(CH_CR);
                end
                default: add_text($urandom_range(1, 6));
            endcase
        end
        else if (pick < 84)
            add_text(($urandom_range(399) == 0) ? 530 : $urandom_range(1, 30));
        else if (pick < 89)
            ;
        else if (pick < 95)
        begin
            repeat ($urandom_range(1, 8))
                line_buf.push_back($urandom_range(1) ? rand_wide()
                                                     : CHAR_W'($urandom_range(1114111)));
        end
        else
        begin
            add_text($urandom_range(5));
            send_buf(1'b0);
            send_word(REQ_END, CHAR_W'($urandom_range(1114111)));
            return;
        end
        send_buf(1'b1);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.req_type  = REQ_CHAR;
        chars.char_code = '0;
        lines.ready     = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_keyword(1'b0);
        // directed: empty end, lone brace, header, fenced brace, extreme code points
        send_word(REQ_END, '0);
        add_str("}");
        send_buf(1'b1);
        add_str("example a{");
        send_buf(1'b1);
        add_str("~~~");
        send_buf(1'b1);
        add_str("}");
        send_buf(1'b1);
        add_str("~~~");
        send_buf(1'b1);
        line_buf.push_back('0);
        line_buf.push_back(CHAR_W'(1114111));
        send_buf(1'b0);
        send_word(REQ_END, CHAR_W'(1114111));
        drain();
        write_keyword(1'b1);
        add_str("test b{");
        send_buf(1'b1);
        // a backtick run that wraps the fence length to zero, on a line past the line limit
        repeat (256) line_buf.push_back(CH_BACKTICK);
        add_str("x");
        add_text(259);
        send_buf(1'b1);

        for (int seg = 0; seg < 6; seg++)
        begin
            drain();
            send_idle_pct = (seg < 2) ? 25 : (seg < 4) ? 70 : 0;
            recv_idle_pct = (seg < 2) ? 70 : (seg < 4) ? 25 : 0;
            write_keyword(seg[0] ? 1'b0 : 1'b1);
            seg_count = 0;
            while (seg_count < SEG_WORDS)
            begin
                random_line();
                if ($urandom_range(99) == 0) drain();
            end
        end

        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("[prose_block_line_terminator_scanner] OK");
        else
            $display("[prose_block_line_terminator_scanner] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
src/plbt_pkg.sv
src/plbt_in_if.sv
src/plbt_out_if.sv
src/prose_block_line_terminator_scanner.sv
tb/plbt_line_checker.sv
tb/tb_top.sv
